// ===== rtl/mpm_pkg.sv =====
// Shared constants, types and helpers for the minimum-peak schedule search block.
`default_nettype none
package mpm_pkg;

  localparam int MAX_NODES = 8;
  localparam int NODE_W    = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int CNT_W     = $clog2(MAX_NODES + 1);
  localparam int SS_W      = MAX_NODES;
  localparam int SUBSETS   = 1 << SS_W;
  localparam int WADDR_W   = 2 * NODE_W;
  localparam int SADDR_W   = SS_W + NODE_W;
  localparam int WEIGHT_W  = 16;
  localparam int PEAK_W    = 31;
  localparam int NC_W      = 4;

  localparam logic [PEAK_W-1:0] PEAK_INF = {PEAK_W{1'b1}};
  localparam logic [PEAK_W-1:0] SUM_MAX  = PEAK_INF - PEAK_W'(1);

  typedef logic [NODE_W-1:0] node_t;
  typedef logic [PEAK_W-1:0] peak_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_INIT, OP_SS_RD, OP_SS_CHK, OP_LD_RD, OP_LD_WR,
    OP_ND, OP_ND_BEST, OP_SL, OP_BK_RD, OP_BK_ACC, OP_FW_RD, OP_FW_ACC,
    OP_OV_ROW, OP_OV_RD, OP_OV_ACC, OP_SELF_RD, OP_SELF_ACC, OP_PK, OP_CMP,
    OP_WB, OP_SS_NEXT, OP_FIN_RD, OP_FIN_OUT
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic ss_inf;
    logic m_zero;
    logic ld_last;
    logic nd_done;
    logic nd_skip;
    logic s_zero;
    logic s_eq_m;
    logic bk_last;
    logic fw_last;
    logic b_last;
    logic a_last;
    logic pk_last;
    logic slot_low;
    logic keep_any;
    logic wb_last;
    logic ss_last;
  } stat_t;

  // {overflow, saturated sum}
  function automatic logic [PEAK_W:0] sat_add(input peak_t a, input peak_t b);
    logic [PEAK_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s > {1'b0, SUM_MAX}) begin
      sat_add = {1'b1, SUM_MAX};
    end else begin
      sat_add = s;
    end
  endfunction

endpackage
`default_nettype wire

// ===== rtl/min_peak_memory_schedule_dp.sv =====
// Top level: register port, sequencer and datapath of the minimum-peak schedule search.
//
//   channel  ports                                   handshake
//   input    in_weight, in_last_entry                start && !busy
//   result   out_min_peak, out_saturated             out_valid, one cycle
//   config   psel penable pwrite paddr pwdata prdata write on psel&penable&pwrite
//
// Matrix words load one per cycle while busy is low. A word with in_last_entry
// set starts the search; busy then stays high while each subset is visited:
// the stored order of a reachable subset is read, the nodes are scanned, each
// admitted node is tried at every insertion slot down to the slot after its
// last predecessor, and an improved order is written back.
// The result is on the ports for one cycle, in the cycle where busy is low
// again. rst_n is synchronous; node_count resets to 8. No back-pressure.
`default_nettype none
module min_peak_memory_schedule_dp (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [mpm_pkg::WEIGHT_W-1:0]     in_weight,
  input  logic                             in_last_entry,
  output logic                             out_valid,
  output logic [mpm_pkg::PEAK_W-1:0]       out_min_peak,
  output logic                             out_saturated,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [1:0]                       paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);
  import mpm_pkg::*;

  logic [NC_W-1:0]  node_count_r;
  logic [CNT_W-1:0] n_eff;
  logic             cfg_wr;
  cmd_t             cmd;
  stat_t            stat;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr == 2'd0) ? {{(32 - NC_W){1'b0}}, node_count_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= NC_W'(MAX_NODES);
    end else if (cfg_wr) begin
      node_count_r <= pwdata[NC_W-1:0];
    end
  end

  always_comb begin
    if (node_count_r == '0) n_eff = CNT_W'(1);
    else if (node_count_r > NC_W'(MAX_NODES)) n_eff = CNT_W'(MAX_NODES);
    else n_eff = CNT_W'(node_count_r);
  end

  mpm_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .in_last_entry(in_last_entry),
    .stat(stat), .cmd(cmd), .busy(busy)
  );

  mpm_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .cfg_wr(cfg_wr), .n_eff(n_eff),
    .in_weight(in_weight), .in_last_entry(in_last_entry), .stat(stat),
    .out_valid(out_valid), .out_min_peak(out_min_peak), .out_saturated(out_saturated)
  );

endmodule
`default_nettype wire

// ===== rtl/mpm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module mpm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/mpm_ctrl.sv =====
// Sequencer for loading and the subset search.
`default_nettype none
module mpm_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic           in_last_entry,
  input  mpm_pkg::stat_t stat,
  output mpm_pkg::cmd_t  cmd,
  output logic           busy
);
  import mpm_pkg::*;

  typedef enum logic [23:0] {
    S_IDLE     = 24'h000001,
    S_INIT     = 24'h000002,
    S_SS_RD    = 24'h000004,
    S_SS_CHK   = 24'h000008,
    S_LD_RD    = 24'h000010,
    S_LD_WR    = 24'h000020,
    S_ND       = 24'h000040,
    S_ND_BEST  = 24'h000080,
    S_SL       = 24'h000100,
    S_BK_RD    = 24'h000200,
    S_BK_ACC   = 24'h000400,
    S_FW_RD    = 24'h000800,
    S_FW_ACC   = 24'h001000,
    S_OV_ROW   = 24'h002000,
    S_OV_RD    = 24'h004000,
    S_OV_ACC   = 24'h008000,
    S_SELF_RD  = 24'h010000,
    S_SELF_ACC = 24'h020000,
    S_PK       = 24'h040000,
    S_CMP      = 24'h080000,
    S_WB       = 24'h100000,
    S_SS_NEXT  = 24'h200000,
    S_FIN_RD   = 24'h400000,
    S_FIN_OUT  = 24'h800000
  } state_t;

  state_t state_r, state_nxt, after_bk;

  always_comb begin
    after_bk = stat.s_eq_m ? S_SELF_RD : S_FW_RD;
    state_nxt = state_r;
    case (state_r)
      S_IDLE:     if (start && in_last_entry) state_nxt = S_INIT;
      S_INIT:     state_nxt = S_SS_RD;
      S_SS_RD:    state_nxt = S_SS_CHK;
      S_SS_CHK: begin
        if (stat.ss_inf) state_nxt = S_SS_NEXT;
        else if (stat.m_zero) state_nxt = S_ND;
        else state_nxt = S_LD_RD;
      end
      S_LD_RD:    state_nxt = S_LD_WR;
      S_LD_WR:    state_nxt = stat.ld_last ? S_ND : S_LD_RD;
      S_ND: begin
        if (stat.nd_done) state_nxt = S_SS_NEXT;
        else if (!stat.nd_skip) state_nxt = S_ND_BEST;
      end
      S_ND_BEST:  state_nxt = S_SL;
      S_SL:       state_nxt = stat.s_zero ? after_bk : S_BK_RD;
      S_BK_RD:    state_nxt = S_BK_ACC;
      S_BK_ACC:   state_nxt = stat.bk_last ? after_bk : S_BK_RD;
      S_FW_RD:    state_nxt = S_FW_ACC;
      S_FW_ACC: begin
        if (!stat.fw_last) state_nxt = S_FW_RD;
        else state_nxt = stat.s_zero ? S_SELF_RD : S_OV_ROW;
      end
      S_OV_ROW:   state_nxt = S_OV_RD;
      S_OV_RD:    state_nxt = S_OV_ACC;
      S_OV_ACC: begin
        if (!stat.b_last) state_nxt = S_OV_RD;
        else state_nxt = stat.a_last ? S_SELF_RD : S_OV_ROW;
      end
      S_SELF_RD:  state_nxt = S_SELF_ACC;
      S_SELF_ACC: state_nxt = S_PK;
      S_PK:       if (stat.pk_last) state_nxt = S_CMP;
      S_CMP: begin
        if (!stat.slot_low) state_nxt = S_SL;
        else state_nxt = stat.keep_any ? S_WB : S_ND;
      end
      S_WB:       if (stat.wb_last) state_nxt = S_ND;
      S_SS_NEXT:  state_nxt = stat.ss_last ? S_FIN_RD : S_SS_RD;
      S_FIN_RD:   state_nxt = S_FIN_OUT;
      S_FIN_OUT:  state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    case (state_r)
      S_IDLE:     cmd.op = start ? OP_LOAD : OP_NONE;
      S_INIT:     cmd.op = OP_INIT;
      S_SS_RD:    cmd.op = OP_SS_RD;
      S_SS_CHK:   cmd.op = OP_SS_CHK;
      S_LD_RD:    cmd.op = OP_LD_RD;
      S_LD_WR:    cmd.op = OP_LD_WR;
      S_ND:       cmd.op = OP_ND;
      S_ND_BEST:  cmd.op = OP_ND_BEST;
      S_SL:       cmd.op = OP_SL;
      S_BK_RD:    cmd.op = OP_BK_RD;
      S_BK_ACC:   cmd.op = OP_BK_ACC;
      S_FW_RD:    cmd.op = OP_FW_RD;
      S_FW_ACC:   cmd.op = OP_FW_ACC;
      S_OV_ROW:   cmd.op = OP_OV_ROW;
      S_OV_RD:    cmd.op = OP_OV_RD;
      S_OV_ACC:   cmd.op = OP_OV_ACC;
      S_SELF_RD:  cmd.op = OP_SELF_RD;
      S_SELF_ACC: cmd.op = OP_SELF_ACC;
      S_PK:       cmd.op = OP_PK;
      S_CMP:      cmd.op = OP_CMP;
      S_WB:       cmd.op = OP_WB;
      S_SS_NEXT:  cmd.op = OP_SS_NEXT;
      S_FIN_RD:   cmd.op = OP_FIN_RD;
      S_FIN_OUT:  cmd.op = OP_FIN_OUT;
      default:    cmd.op = OP_NONE;
    endcase
  end

  assign busy = (state_r != S_IDLE);

endmodule
`default_nettype wire

// ===== rtl/mpm_dp.sv =====
// Datapath: weight store, subset tables, insertion trial registers and saturating sums.
`default_nettype none
module mpm_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mpm_pkg::cmd_t                 cmd,
  input  logic                          cfg_wr,
  input  logic [mpm_pkg::CNT_W-1:0]     n_eff,
  input  logic [mpm_pkg::WEIGHT_W-1:0]  in_weight,
  input  logic                          in_last_entry,
  output mpm_pkg::stat_t                stat,
  output logic                          out_valid,
  output logic [mpm_pkg::PEAK_W-1:0]    out_min_peak,
  output logic                          out_saturated
);
  import mpm_pkg::*;

  // load position
  logic [CNT_W-1:0] lrow_r, lcol_r;
  logic [MAX_NODES-1:0] pred_r [MAX_NODES];

  // search state
  logic [SS_W-1:0]    ss_r, tgt_r, full_w;
  logic [SUBSETS-1:0] valid_r;
  logic [CNT_W-1:0]   node_r, m_r, m_calc;
  node_t slot_r, low_r, idx_r, fidx_r, a_r, b_r, row_r;
  peak_t back_r, fwd_r, ovhd_r, peak_r, best_r;
  logic  found_r, sat_r;

  node_t cur_ord_r  [MAX_NODES];
  peak_t cur_live_r [MAX_NODES];
  node_t pos_r      [MAX_NODES];
  node_t cand_ord_r [MAX_NODES];
  peak_t cand_live_r[MAX_NODES];
  node_t keep_ord_r [MAX_NODES];
  peak_t keep_live_r[MAX_NODES];

  logic  out_valid_r, out_sat_r;
  peak_t out_peak_r;

  // memories
  logic                  w_we;
  logic [WADDR_W-1:0]    w_waddr, w_raddr;
  logic [WEIGHT_W-1:0]   w_rdata;
  logic                  b_we;
  logic [SS_W-1:0]       b_waddr, b_raddr;
  peak_t                 b_wdata, b_rdata;
  logic                  s_we;
  logic [SADDR_W-1:0]    s_waddr, s_raddr;
  logic [NODE_W+PEAK_W-1:0] s_wdata, s_rdata;

  node_t p, co_idx, cl_idx, co, mp, low_calc;
  peak_t cl, w_ext, acc_in;
  logic [MAX_NODES-1:0] pred_sel;
  logic  ok, has_pred, better;
  logic [PEAK_W:0] acc1, acc2, t1, t2, t3;

  assign p        = node_r[NODE_W-1:0];
  assign pred_sel = pred_r[p];
  assign ok       = ((pred_sel & ~ss_r) == '0);
  assign w_ext    = PEAK_W'(w_rdata);
  assign better   = (peak_r < best_r);

  always_comb begin
    for (int i = 0; i < MAX_NODES; i++) begin
      full_w[i] = (CNT_W'(i) < n_eff);
    end
    m_calc = '0;
    for (int i = 0; i < MAX_NODES; i++) begin
      m_calc = m_calc + CNT_W'(ss_r[i]);
    end
    has_pred = 1'b0;
    mp = '0;
    for (int c = 0; c < MAX_NODES; c++) begin
      if (pred_sel[c] && (!has_pred || pos_r[c] > mp)) begin
        has_pred = 1'b1;
        mp = pos_r[c];
      end
    end
    low_calc = has_pred ? mp + NODE_W'(1) : '0;
  end

  // one read index each for the candidate order and live arrays
  always_comb begin
    case (cmd.op)
      OP_FW_RD:  co_idx = fidx_r;
      OP_OV_ROW: co_idx = a_r;
      OP_OV_RD:  co_idx = b_r;
      default:   co_idx = idx_r;
    endcase
    co = cand_ord_r[co_idx];
    cl_idx = (cmd.op == OP_FW_ACC) ? fidx_r : idx_r;
    cl = cand_live_r[cl_idx];
  end

  always_comb begin
    case (cmd.op)
      OP_BK_RD:   w_raddr = {co, p};
      OP_FW_RD:   w_raddr = {p, co};
      OP_OV_RD:   w_raddr = {row_r, co};
      default:    w_raddr = {p, p};
    endcase
    case (cmd.op)
      OP_ND:      b_raddr = ss_r | (SS_W'(1) << p);
      OP_FIN_RD:  b_raddr = full_w;
      default:    b_raddr = ss_r;
    endcase
    case (cmd.op)
      OP_FW_ACC:  acc_in = fwd_r;
      OP_OV_ACC:  acc_in = ovhd_r;
      default:    acc_in = back_r;
    endcase
    acc1 = sat_add(acc_in, w_ext);
    acc2 = sat_add(cl, acc1[PEAK_W-1:0]);
    t1 = sat_add(ovhd_r, fwd_r);
    t2 = sat_add(t1[PEAK_W-1:0], back_r);
    t3 = sat_add(t2[PEAK_W-1:0], w_ext);
  end

  assign w_we    = (cmd.op == OP_LOAD) && (lrow_r < n_eff);
  assign w_waddr = {lrow_r[NODE_W-1:0], lcol_r[NODE_W-1:0]};

  assign b_we    = (cmd.op == OP_INIT) || ((cmd.op == OP_WB) && (idx_r == '0));
  assign b_waddr = (cmd.op == OP_INIT) ? '0 : tgt_r;
  assign b_wdata = (cmd.op == OP_INIT) ? '0 : best_r;

  assign s_we    = (cmd.op == OP_WB);
  assign s_waddr = {tgt_r, idx_r};
  assign s_wdata = {keep_ord_r[idx_r], keep_live_r[idx_r]};
  assign s_raddr = {ss_r, idx_r};

  mpm_ram #(.WIDTH(WEIGHT_W), .DEPTH(1 << WADDR_W)) u_wram (
    .clk(clk), .we(w_we), .waddr(w_waddr), .wdata(in_weight),
    .raddr(w_raddr), .rdata(w_rdata)
  );

  mpm_ram #(.WIDTH(PEAK_W), .DEPTH(SUBSETS)) u_bram (
    .clk(clk), .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
    .raddr(b_raddr), .rdata(b_rdata)
  );

  mpm_ram #(.WIDTH(NODE_W + PEAK_W), .DEPTH(1 << SADDR_W)) u_sram (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
    .raddr(s_raddr), .rdata(s_rdata)
  );

  always_comb begin
    stat.ss_inf   = !valid_r[ss_r];
    stat.m_zero   = (m_calc == '0);
    stat.ld_last  = (CNT_W'(idx_r) == m_r - CNT_W'(1));
    stat.nd_done  = (node_r == n_eff);
    stat.nd_skip  = ss_r[p] || !ok;
    stat.s_zero   = (slot_r == '0);
    stat.s_eq_m   = (CNT_W'(slot_r) == m_r);
    stat.bk_last  = (idx_r == slot_r - NODE_W'(1));
    stat.fw_last  = (fidx_r == slot_r + NODE_W'(1));
    stat.b_last   = (CNT_W'(b_r) == m_r);
    stat.a_last   = (a_r == slot_r - NODE_W'(1));
    stat.pk_last  = (CNT_W'(idx_r) == m_r);
    stat.slot_low = (slot_r == low_r);
    stat.keep_any = found_r || better;
    stat.wb_last  = (CNT_W'(idx_r) == m_r);
    stat.ss_last  = (ss_r == full_w);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lrow_r      <= '0;
      lcol_r      <= '0;
      out_valid_r <= 1'b0;
      valid_r     <= '0;
      sat_r       <= 1'b0;
      for (int i = 0; i < MAX_NODES; i++) pred_r[i] <= '0;
    end else begin
      out_valid_r <= 1'b0;
      if (cfg_wr) begin
        lrow_r <= '0;
        lcol_r <= '0;
      end
      case (cmd.op)
        OP_LOAD: begin
          if (w_we) begin
            if (lrow_r < lcol_r) begin
              pred_r[lcol_r[NODE_W-1:0]][lrow_r[NODE_W-1:0]] <= (in_weight != '0);
            end
            if (lcol_r == n_eff - CNT_W'(1)) begin
              lcol_r <= '0;
              lrow_r <= lrow_r + CNT_W'(1);
            end else begin
              lcol_r <= lcol_r + CNT_W'(1);
            end
          end
          if (in_last_entry) begin
            lrow_r <= '0;
            lcol_r <= '0;
          end
        end
        OP_INIT: begin
          valid_r    <= '0;
          valid_r[0] <= 1'b1;
          sat_r      <= 1'b0;
          ss_r       <= '0;
        end
        OP_SS_CHK: begin
          m_r    <= m_calc;
          idx_r  <= '0;
          node_r <= '0;
          for (int i = 0; i < MAX_NODES; i++) pos_r[i] <= '0;
        end
        OP_LD_WR: begin
          cur_ord_r[idx_r]  <= s_rdata[NODE_W+PEAK_W-1:PEAK_W];
          cur_live_r[idx_r] <= s_rdata[PEAK_W-1:0];
          pos_r[s_rdata[NODE_W+PEAK_W-1:PEAK_W]] <= idx_r;
          idx_r <= idx_r + NODE_W'(1);
        end
        OP_ND: begin
          if (!stat.nd_done) begin
            if (stat.nd_skip) begin
              node_r <= node_r + CNT_W'(1);
            end else begin
              tgt_r   <= ss_r | (SS_W'(1) << p);
              slot_r  <= m_r[NODE_W-1:0];
              low_r   <= low_calc;
              found_r <= 1'b0;
            end
          end
        end
        OP_ND_BEST: best_r <= valid_r[tgt_r] ? b_rdata : PEAK_INF;
        OP_SL: begin
          for (int i = 0; i < MAX_NODES; i++) begin
            if (NODE_W'(i) < slot_r) begin
              cand_ord_r[i]  <= cur_ord_r[i];
              cand_live_r[i] <= cur_live_r[i];
            end else if (NODE_W'(i) == slot_r) begin
              cand_ord_r[i]  <= p;
              cand_live_r[i] <= '0;
            end else begin
              cand_ord_r[i]  <= cur_ord_r[(i > 0) ? i - 1 : 0];
              cand_live_r[i] <= cur_live_r[(i > 0) ? i - 1 : 0];
            end
          end
          back_r <= '0;
          fwd_r  <= '0;
          ovhd_r <= '0;
          idx_r  <= '0;
          fidx_r <= m_r[NODE_W-1:0];
          a_r    <= '0;
        end
        OP_BK_ACC: begin
          back_r <= acc1[PEAK_W-1:0];
          cand_live_r[cl_idx] <= acc2[PEAK_W-1:0];
          sat_r  <= sat_r | acc1[PEAK_W] | acc2[PEAK_W];
          idx_r  <= idx_r + NODE_W'(1);
        end
        OP_FW_ACC: begin
          fwd_r  <= acc1[PEAK_W-1:0];
          cand_live_r[cl_idx] <= acc2[PEAK_W-1:0];
          sat_r  <= sat_r | acc1[PEAK_W] | acc2[PEAK_W];
          fidx_r <= fidx_r - NODE_W'(1);
        end
        OP_OV_ROW: begin
          row_r <= co;
          b_r   <= slot_r + NODE_W'(1);
        end
        OP_OV_ACC: begin
          ovhd_r <= acc1[PEAK_W-1:0];
          sat_r  <= sat_r | acc1[PEAK_W];
          if (stat.b_last) a_r <= a_r + NODE_W'(1);
          else b_r <= b_r + NODE_W'(1);
        end
        OP_SELF_ACC: begin
          cand_live_r[slot_r] <= t3[PEAK_W-1:0];
          sat_r  <= sat_r | t1[PEAK_W] | t2[PEAK_W] | t3[PEAK_W];
          idx_r  <= '0;
          peak_r <= '0;
        end
        OP_PK: begin
          if (cl > peak_r) peak_r <= cl;
          idx_r <= idx_r + NODE_W'(1);
        end
        OP_CMP: begin
          if (better) begin
            best_r  <= peak_r;
            found_r <= 1'b1;
            for (int i = 0; i < MAX_NODES; i++) begin
              keep_ord_r[i]  <= cand_ord_r[i];
              keep_live_r[i] <= cand_live_r[i];
            end
          end
          if (!stat.slot_low) begin
            slot_r <= slot_r - NODE_W'(1);
          end else if (stat.keep_any) begin
            idx_r <= '0;
          end else begin
            node_r <= node_r + CNT_W'(1);
          end
        end
        OP_WB: begin
          if (idx_r == '0) valid_r[tgt_r] <= 1'b1;
          idx_r <= idx_r + NODE_W'(1);
          if (stat.wb_last) node_r <= node_r + CNT_W'(1);
        end
        OP_SS_NEXT: ss_r <= ss_r + SS_W'(1);
        OP_FIN_OUT: begin
          out_valid_r <= 1'b1;
          out_peak_r  <= valid_r[full_w] ? b_rdata : PEAK_INF;
          out_sat_r   <= sat_r;
        end
        default: ;
      endcase
    end
  end

  assign out_valid     = out_valid_r;
  assign out_min_peak  = out_peak_r;
  assign out_saturated = out_sat_r;

endmodule
`default_nettype wire
